[hdl/tcab_pkg.sv]
// types, constants and helpers for the totalistic pixel row blend
// no dependencies; imported by every module of the block
`default_nettype none
package tcab_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int RATIO_BITS  = 9;
    localparam int SUM_BITS    = 10;
    localparam int CLASS_BITS  = 3;
    localparam int NUM_CLASSES = 6;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE     = 9'd256;
    localparam logic [SUM_BITS-1:0]   CLASS_DIVISOR = 10'd132;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RATIO       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_FIRST = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_LAST  = 3'd6;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [CLASS_BITS-1:0] class_t;

    typedef struct packed {
        pixel_t target_pixel;
        pixel_t canvas_pixel;
        logic   row_start;
        logic   row_end;
        logic   pass_row;
    } in_item_t;

    typedef struct packed {
        pixel_t new_pixel;
        logic   last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_LEFT,
        PH_MIDDLE
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    // neighbourhood class: sum of three blends divided by 132, top class five
    function automatic class_t sum_class(input logic [SUM_BITS-1:0] sum);
        class_t cls;
        if (sum >= 5 * CLASS_DIVISOR)
            cls = 3'd5;
        else if (sum >= 4 * CLASS_DIVISOR)
            cls = 3'd4;
        else if (sum >= 3 * CLASS_DIVISOR)
            cls = 3'd3;
        else if (sum >= 2 * CLASS_DIVISOR)
            cls = 3'd2;
        else if (sum >= CLASS_DIVISOR)
            cls = 3'd1;
        else
            cls = 3'd0;
        return cls;
    endfunction

endpackage
`default_nettype wire

[hdl/tcab_mix.sv]
// shared blend unit: (t*(256-r) + d*r) >> 8, as t*256 + (d-t)*r
// depends on tcab_pkg
`default_nettype none
module tcab_mix (
    input  wire tcab_pkg::pixel_t               t,
    input  wire tcab_pkg::pixel_t               d,
    input  wire [tcab_pkg::RATIO_BITS-1:0]      r,
    output tcab_pkg::pixel_t                    y
);
    import tcab_pkg::*;

    localparam int PROD_BITS = PIXEL_BITS + 1 + RATIO_BITS + 1;

    logic signed [PIXEL_BITS:0]   diff;
    logic signed [PROD_BITS-1:0]  diff_w;
    logic signed [PROD_BITS-1:0]  r_w;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0]  total;

    assign diff   = $signed({1'b0, d}) - $signed({1'b0, t});
    // both factors at full product width so the multiply cannot wrap
    assign diff_w = {{(PROD_BITS-PIXEL_BITS-1){diff[PIXEL_BITS]}}, diff};
    assign r_w    = {{(PROD_BITS-RATIO_BITS){1'b0}}, r};
    assign prod   = diff_w * r_w;
    // the total never goes negative, so the slice is the truncated blend
    assign total  = $signed({{(PROD_BITS-PIXEL_BITS-8){1'b0}}, t, 8'd0}) + prod;
    assign y      = total[PIXEL_BITS+7:8];

endmodule
`default_nettype wire

[hdl/tcab_cfg.sv]
// configuration registers: overlay ratio and the six rule table levels
// depends on tcab_pkg
`default_nettype none
module tcab_cfg (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_we,
    input  wire [tcab_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire [tcab_pkg::RATIO_BITS-1:0]       cfg_wdata,
    input  wire tcab_pkg::class_t                cls,
    output logic [tcab_pkg::RATIO_BITS-1:0]      ratio,
    output tcab_pkg::pixel_t                     level
);
    import tcab_pkg::*;

    logic [RATIO_BITS-1:0] ratio_reg;
    pixel_t                level_reg [NUM_CLASSES];
    class_t                slot;

    assign slot = class_t'(cfg_index - CFG_LEVEL_FIRST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_ONE;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                level_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == CFG_RATIO) begin
                ratio_reg <= cfg_wdata;
            end else if (cfg_index >= CFG_LEVEL_FIRST && cfg_index <= CFG_LEVEL_LAST) begin
                level_reg[slot] <= cfg_wdata[PIXEL_BITS-1:0];
            end
        end
    end

    // ratios above one saturate
    assign ratio = (ratio_reg > RATIO_ONE) ? RATIO_ONE : ratio_reg;

    always_comb begin
        level = level_reg[NUM_CLASSES-1];
        if (cls < class_t'(NUM_CLASSES))
            level = level_reg[cls];
    end

endmodule
`default_nettype wire

[hdl/totalistic_ca_pixel_row_blend.sv]
// Three-cell totalistic automaton over raster pixel rows, blended with a target
// image. Each accepted pixel pair is handled by a small sequencer around one
// shared blend unit. A row start, an end pixel or a pixel of a pass row is
// accepted, then its result is loaded into the output register; when a row
// start also flushes the held middle pixel of an unfinished row, that pixel
// is loaded first and the new one after it. The second pixel of a row is
// only held and gives no result. An inner pixel whose right neighbour
// arrives is accepted, makes four passes through the blend unit (left, middle
// and right blends summed, then the middle target blended with the chosen
// level), then has its result loaded; a second result follows when the same
// request also closes the row. Every load waits while the output register is
// full and m_ready is low. s_ready is high whenever the sequencer is idle,
// even while a result still waits in the output register; results leave in
// raster order and last_of_run marks the last one caused by each request.
// depends on tcab_pkg, tcab_mix and tcab_cfg
`default_nettype none
module totalistic_ca_pixel_row_blend (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire tcab_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output tcab_pkg::out_item_t                  m_data,
    input  wire                                  cfg_we,
    input  wire [tcab_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire [tcab_pkg::RATIO_BITS-1:0]       cfg_wdata
);
    import tcab_pkg::*;

    state_t            state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    phase_t            phase_reg, phase_next;
    logic              passing_reg, passing_next;
    pixel_t            held_t_reg, held_t_next;
    pixel_t            held_c_reg, held_c_next;
    pixel_t            left_t_reg, left_t_next;
    pixel_t            left_u_reg, left_u_next;
    pixel_t            in_t_reg, in_t_next;
    pixel_t            in_c_reg, in_c_next;
    logic              in_re_reg, in_re_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    pixel_t            pend_a_reg, pend_a_next;
    pixel_t            pend_b_reg, pend_b_next;
    logic              pend_two_reg, pend_two_next;
    out_item_t         out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic              slot_free;
    logic              load;
    pixel_t            mix_t, mix_d, mix_y, level;
    logic [RATIO_BITS-1:0] ratio;
    class_t            cls;

    assign cls = sum_class(sum_reg);

    tcab_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cls       (cls),
        .ratio     (ratio),
        .level     (level)
    );

    tcab_mix u_mix (
        .t (mix_t),
        .d (mix_d),
        .r (ratio),
        .y (mix_y)
    );

    // operand select of the shared blend unit
    always_comb begin
        case (step_reg)
            2'd0: begin
                mix_t = left_t_reg;
                mix_d = left_u_reg;
            end
            2'd1: begin
                mix_t = held_t_reg;
                mix_d = held_c_reg;
            end
            2'd2: begin
                mix_t = in_t_reg;
                mix_d = in_c_reg;
            end
            default: begin
                mix_t = held_t_reg;
                mix_d = level;
            end
        endcase
    end

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        phase_next    = phase_reg;
        passing_next  = passing_reg;
        held_t_next   = held_t_reg;
        held_c_next   = held_c_reg;
        left_t_next   = left_t_reg;
        left_u_next   = left_u_reg;
        in_t_next     = in_t_reg;
        in_c_next     = in_c_reg;
        in_re_next    = in_re_reg;
        sum_next      = sum_reg;
        pend_a_next   = pend_a_reg;
        pend_b_next   = pend_b_reg;
        pend_two_next = pend_two_reg;
        out_next      = out_reg;
        load          = 1'b0;
        s_ready       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_t_next  = s_data.target_pixel;
                    in_c_next  = s_data.canvas_pixel;
                    in_re_next = s_data.row_end;
                    if (s_data.row_start || phase_reg == PH_EMPTY) begin
                        passing_next = s_data.pass_row;
                        // an unfinished row flushes its held middle pixel first
                        if (phase_reg == PH_MIDDLE) begin
                            pend_a_next   = held_c_reg;
                            pend_b_next   = s_data.canvas_pixel;
                            pend_two_next = 1'b1;
                        end else begin
                            pend_a_next   = s_data.canvas_pixel;
                            pend_two_next = 1'b0;
                        end
                        if (s_data.row_end) begin
                            phase_next = PH_EMPTY;
                        end else begin
                            phase_next  = PH_LEFT;
                            left_t_next = s_data.target_pixel;
                            left_u_next = s_data.canvas_pixel;
                        end
                        state_next = ST_EMIT_A;
                    end else if (passing_reg) begin
                        pend_a_next   = s_data.canvas_pixel;
                        pend_two_next = 1'b0;
                        phase_next    = s_data.row_end ? PH_EMPTY : PH_LEFT;
                        state_next    = ST_EMIT_A;
                    end else if (phase_reg == PH_LEFT) begin
                        if (s_data.row_end) begin
                            pend_a_next   = s_data.canvas_pixel;
                            pend_two_next = 1'b0;
                            phase_next    = PH_EMPTY;
                            state_next    = ST_EMIT_A;
                        end else begin
                            held_t_next = s_data.target_pixel;
                            held_c_next = s_data.canvas_pixel;
                            phase_next  = PH_MIDDLE;
                        end
                    end else begin
                        step_next  = 2'd0;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd0: sum_next = {2'b00, mix_y};
                    2'd1: sum_next = sum_reg + {2'b00, mix_y};
                    2'd2: sum_next = sum_reg + {2'b00, mix_y};
                    default: begin
                        // updated middle becomes the next left neighbour
                        left_t_next   = held_t_reg;
                        left_u_next   = mix_y;
                        pend_a_next   = mix_y;
                        pend_b_next   = in_c_reg;
                        pend_two_next = in_re_reg;
                        if (in_re_reg) begin
                            phase_next = PH_EMPTY;
                        end else begin
                            held_t_next = in_t_reg;
                            held_c_next = in_c_reg;
                            phase_next  = PH_MIDDLE;
                        end
                        state_next = ST_EMIT_A;
                    end
                endcase
            end
            ST_EMIT_A: begin
                if (slot_free) begin
                    load                 = 1'b1;
                    out_next.new_pixel   = pend_a_reg;
                    out_next.last_of_run = !pend_two_reg;
                    state_next           = pend_two_reg ? ST_EMIT_B : ST_IDLE;
                end
            end
            ST_EMIT_B: begin
                if (slot_free) begin
                    load                 = 1'b1;
                    out_next.new_pixel   = pend_b_reg;
                    out_next.last_of_run = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= 2'd0;
            phase_reg   <= PH_EMPTY;
            passing_reg <= 1'b0;
            held_t_reg  <= '0;
            held_c_reg  <= '0;
            left_t_reg  <= '0;
            left_u_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            passing_reg <= passing_next;
            held_t_reg  <= held_t_next;
            held_c_reg  <= held_c_next;
            left_t_reg  <= left_t_next;
            left_u_reg  <= left_u_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_t_reg     <= in_t_next;
        in_c_reg     <= in_c_next;
        in_re_reg    <= in_re_next;
        sum_reg      <= sum_next;
        pend_a_reg   <= pend_a_next;
        pend_b_reg   <= pend_b_next;
        pend_two_reg <= pend_two_next;
        out_reg      <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire
